// File: sv/iath_pkg.sv
package iath_pkg;

  localparam int NumRounds = 64;
  localparam int NumComp = 4;
  localparam int NumStages = NumRounds * NumComp;

  typedef struct packed {
    logic [63:0] contract_word0;
    logic [63:0] contract_word1;
    logic [63:0] contract_word2;
    logic [63:0] contract_word3;
    logic [63:0] txid_word0;
    logic [63:0] txid_word1;
    logic [63:0] txid_word2;
    logic [63:0] txid_word3;
    logic [31:0] output_index;
  } iath_in_t;

  typedef struct packed {
    logic [63:0] tag_word0;
    logic [63:0] tag_word1;
    logic [63:0] tag_word2;
    logic [63:0] tag_word3;
  } iath_out_t;

  typedef logic [7:0][31:0] iath_state_t;
  typedef logic [15:0][31:0] iath_sched_t;

  localparam logic [63:0][31:0] RoundK = {
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  // Element 0 is word a.
  localparam iath_state_t InitH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bswap(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// File: sv/iath_round_cell.sv
module iath_round_cell import iath_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] k_i,
  input  iath_state_t st_i,
  input  iath_sched_t w_i,
  input  iath_state_t ctx_i,
  output iath_state_t st_o,
  output iath_sched_t w_o,
  output iath_state_t ctx_o
);

  logic [31:0] t1, t2, s0, s1, wn;
  iath_state_t st_d;
  iath_state_t st_q, ctx_q;
  iath_sched_t w_q;

  // One round, plus one step of the message schedule window.
  always_comb begin
    t1 = st_i[7] + (rotr(st_i[4], 6) ^ rotr(st_i[4], 11) ^ rotr(st_i[4], 25))
       + ((st_i[4] & st_i[5]) ^ (~st_i[4] & st_i[6])) + k_i + w_i[0];
    t2 = (rotr(st_i[0], 2) ^ rotr(st_i[0], 13) ^ rotr(st_i[0], 22))
       + ((st_i[0] & st_i[1]) ^ (st_i[0] & st_i[2]) ^ (st_i[1] & st_i[2]));
    st_d = {st_i[6:4], st_i[3] + t1, st_i[2:0], t1 + t2};
    s0 = rotr(w_i[1], 7) ^ rotr(w_i[1], 18) ^ (w_i[1] >> 3);
    s1 = rotr(w_i[14], 17) ^ rotr(w_i[14], 19) ^ (w_i[14] >> 10);
    wn = w_i[0] + s0 + w_i[9] + s1;
  end

  // Advance data to the next cell when the chain moves.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= st_d;
      w_q   <= {wn, w_i[15:1]};
      ctx_q <= ctx_i;
    end
  end

  assign st_o  = st_q;
  assign w_o   = w_q;
  assign ctx_o = ctx_q;

endmodule

// File: sv/iath_compress.sv
module iath_compress import iath_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  iath_sched_t blk_i,
  input  iath_state_t ctx_i,
  output iath_state_t h_o,
  output iath_state_t ctx_o
);

  iath_state_t st [NumRounds+1];
  iath_sched_t w [NumRounds+1];
  iath_state_t cx [NumRounds+1];

  // blk_i element 0 is message word 0.
  assign st[0] = InitH;
  assign w[0]  = blk_i;
  assign cx[0] = ctx_i;

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    iath_round_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .k_i   (RoundK[r]),
      .st_i  (st[r]),
      .w_i   (w[r]),
      .ctx_i (cx[r]),
      .st_o  (st[r+1]),
      .w_o   (w[r+1]),
      .ctx_o (cx[r+1])
    );
  end

  // Add the initial value back in (feed-forward).
  always_comb begin
    for (int i = 0; i < 8; i++) h_o[i] = InitH[i] + st[NumRounds][i];
  end
  assign ctx_o = cx[NumRounds];

endmodule

// File: sv/issued_asset_tag_hasher.sv
// Issued asset tag hasher.
// Input channel in_valid_i/in_ready_o/in_data_i carries one transaction per
// issuance: contract hash, prevout txid and output index. Output channel
// out_valid_o/out_ready_i/out_data_o returns the 32-byte asset tag.
// The datapath is a chain of 256 round cells (four SHA-256 compressions of
// 64 rounds each), one register per cell, with no feedback.
// Throughput: one transaction per cycle while the receiver keeps up.
// The whole chain advances together; when the receiver stalls with a result
// at the chain end, the chain freezes and in_ready_o drops. Bubbles travel
// as cleared valid bits and do not block: the chain moves while the last
// cell holds no result or the result is being taken.
// Reset clears only the per-cell valid bits; payload registers are not reset.
module issued_asset_tag_hasher import iath_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  iath_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output iath_out_t out_data_o
);

  logic en;
  logic [NumStages-1:0] vld_q;
  iath_sched_t blk [NumComp];
  iath_state_t hout [NumComp];
  iath_state_t cin [NumComp];
  iath_state_t cout [NumComp];
  logic [7:0][31:0] ctr_w, txr_w;
  logic [255:0] ctr_bits, txr_bits;

  assign en = !vld_q[NumStages-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vld_q[NumStages-1];

  // Shift the valid bits along the chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // Byte-reverse the 32-byte inputs; word i gets reversed bytes 4i..4i+3.
  assign ctr_bits = {in_data_i.contract_word0, in_data_i.contract_word1,
                     in_data_i.contract_word2, in_data_i.contract_word3};
  assign txr_bits = {in_data_i.txid_word0, in_data_i.txid_word1,
                     in_data_i.txid_word2, in_data_i.txid_word3};
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ctr_w[i] = bswap(ctr_bits[32*i +: 32]);
      txr_w[i] = bswap(txr_bits[32*i +: 32]);
    end
  end

  // Build the message blocks for each compression.
  always_comb begin
    blk[0] = '0;
    for (int i = 0; i < 8; i++) blk[0][i] = txr_w[i];
    blk[0][8]  = bswap(in_data_i.output_index);
    blk[0][9]  = 32'h8000_0000;
    blk[0][15] = 32'd288;
    cin[0] = ctr_w;

    blk[1] = '0;
    for (int i = 0; i < 8; i++) blk[1][i] = hout[0][i];
    blk[1][8]  = 32'h8000_0000;
    blk[1][15] = 32'd256;
    cin[1] = cout[0];

    blk[2] = '0;
    for (int i = 0; i < 8; i++) begin
      blk[2][i]   = hout[1][i];
      blk[2][8+i] = cout[1][i];
    end
    cin[2] = '0;

    blk[3] = '0;
    for (int i = 0; i < 8; i++) blk[3][i] = hout[2][i];
    cin[3] = '0;
  end

  for (genvar c = 0; c < NumComp; c++) begin : g_comp
    iath_compress u_comp (
      .clk_i (clk_i),
      .en_i  (en),
      .blk_i (blk[c]),
      .ctx_i (cin[c]),
      .h_o   (hout[c]),
      .ctx_o (cout[c])
    );
  end

  // Tag is the byte-reversed final state.
  logic [255:0] tag_bits;
  always_comb begin
    for (int i = 0; i < 8; i++) tag_bits[32*i +: 32] = bswap(hout[3][i]);
  end
  assign out_data_o.tag_word0 = tag_bits[255:192];
  assign out_data_o.tag_word1 = tag_bits[191:128];
  assign out_data_o.tag_word2 = tag_bits[127:64];
  assign out_data_o.tag_word3 = tag_bits[63:0];

`ifndef SYNTHESIS
  a_ready_tracks_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o) else $error("ready while stalled");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && !in_valid_i) |=> !vld_q[0]) else $error("invented transaction");
`endif

endmodule
